>>> sv/hefm_pkg.sv
// ----------------------------------------------------------------------------
// hefm_pkg
// Shared types, constants and helpers of the Hall edge meter.
// ----------------------------------------------------------------------------
`default_nettype none

package hefm_pkg;

	localparam int CHANNELS              = 3;
	localparam int CH_W                  = 2;
	localparam int DEFAULT_CAPTURE_DEPTH = 15;
	localparam int TS_W                  = 32;
	localparam int NUM_W                 = 64;
	localparam int DEN_W                 = 40;
	localparam int DUTY_W                = 10;

	localparam logic [NUM_W-1:0] K_PERMILLE  = NUM_W'(1000);
	localparam logic [NUM_W-1:0] K_HALF_TICK = NUM_W'(64'd36000000000);
	localparam logic [NUM_W-1:0] K_TICK      = NUM_W'(64'd72000000000);
	localparam logic [NUM_W-1:0] K_GIGA      = NUM_W'(64'd1000000000);
	localparam logic [NUM_W-1:0] K_RISE_MUL  = NUM_W'(72);
	localparam logic [NUM_W-1:0] K_MDEG      = NUM_W'(360000);
	localparam logic [TS_W-1:0]  SAT_VAL     = '1;

	typedef enum logic [1:0] {
		REQ_CLEAR    = 2'd0,
		REQ_EDGE     = 2'd1,
		REQ_COMPUTE  = 2'd2,
		REQ_RESERVED = 2'd3
	} req_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [NUM_W-1:0] quo;
		logic [DEN_W-1:0] rem;
	} div_rsp_t;

	function automatic logic [TS_W-1:0] sat32(input logic [NUM_W-1:0] v);
		sat32 = (v > NUM_W'(SAT_VAL)) ? SAT_VAL : v[TS_W-1:0];
	endfunction

	function automatic logic [TS_W-1:0] abs_gap(input logic [TS_W-1:0] a,
			input logic [TS_W-1:0] b);
		logic [TS_W-1:0] d;
		d = a - b;
		abs_gap = d[TS_W-1] ? (TS_W'(0) - d) : d;
	endfunction

endpackage

`default_nettype wire

>>> sv/hefm_ram.sv
// ----------------------------------------------------------------------------
// hefm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hefm_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 45
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> sv/hefm_div.sv
// ----------------------------------------------------------------------------
// hefm_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hefm_div
	import hefm_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			quo_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

>>> sv/hall_edge_freq_duty_phase_meter_core.sv
// ----------------------------------------------------------------------------
// hall_edge_freq_duty_phase_meter_core
// Three-channel Hall edge meter: captures edge timestamps, reports duty,
// frequency and phase to channel A per channel on a compute request.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  input   | in_valid / in_stall        | req_type channel level timestamp
//  output  | out_valid / out_stall      | result_channel window_valid
//          |                            | duty_permille freq_millihertz
//          |                            | phase_millideg last_result
//
// A compute walks each channel's stored edges and then runs up to six passes
// of the shared divider (four at most for channel A).
// in_stall is high during the whole compute, until the last result is taken.
// Reset clears counts and rise trackers; the edge RAM needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module hall_edge_freq_duty_phase_meter_core
	import hefm_pkg::*;
#(
	parameter int CAPTURE_DEPTH = DEFAULT_CAPTURE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        req_type,
	input  wire logic [CH_W-1:0]   channel,
	input  wire logic              level,
	input  wire logic [TS_W-1:0]   timestamp,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [CH_W-1:0]        result_channel,
	output logic                   window_valid,
	output logic [DUTY_W-1:0]      duty_permille,
	output logic [TS_W-1:0]        freq_millihertz,
	output logic [TS_W-1:0]        phase_millideg,
	output logic                   last_result
);

	localparam int CNT_W  = $clog2(CAPTURE_DEPTH + 1);
	localparam int DEPTH  = CHANNELS * CAPTURE_DEPTH;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SUM_W  = TS_W + $clog2(CAPTURE_DEPTH);

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_WINIT = 14'b00000000000010,
		S_RD    = 14'b00000000000100,
		S_ACC   = 14'b00000000001000,
		S_EVAL  = 14'b00000000010000,
		S_DUTY  = 14'b00000000100000,
		S_WFREQ = 14'b00000001000000,
		S_RSEL  = 14'b00000010000000,
		S_RISE1 = 14'b00000100000000,
		S_RISE2 = 14'b00001000000000,
		S_PSEL  = 14'b00010000000000,
		S_PH1   = 14'b00100000000000,
		S_PH2   = 14'b01000000000000,
		S_OUT   = 14'b10000000000000
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0] cnt_q        [CHANNELS];
	logic [TS_W-1:0]  rise_cnt_q   [CHANNELS];
	logic [TS_W-1:0]  first_rise_q [CHANNELS];
	logic [TS_W-1:0]  last_rise_q  [CHANNELS];

	logic [CH_W-1:0]  k_q;
	logic [CNT_W-1:0] n_q, p_q, i_q;
	logic [SUM_W-1:0] total_q, high_q;
	logic [TS_W-1:0]  prev_t_q, ref_q, aref_q, wfreq_q, wfreq0_q, gap_q, rrem_q;
	logic [TS_W-1:0]  raw_q;
	logic [DEN_W-1:0] per_q;
	logic [2:0]       rq_q;
	logic             prev_lvl_q, found_q, valid_q, valid0_q, wait_q;
	logic [DUTY_W-1:0] duty_q;
	logic [TS_W-1:0]  freq_q, phase_q;

	logic             in_acc, out_acc, edge_ok, ram_we, ram_re;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [TS_W:0]    rdata;
	logic [TS_W-1:0]  rd_t, gap_d, rise_gap;
	logic             rd_l;
	div_req_t         dreq;
	div_rsp_t         drsp;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign edge_ok = (req_type == REQ_EDGE) && (channel < CH_W'(CHANNELS));
	assign ram_we  = in_acc && edge_ok && (cnt_q[channel] < CNT_W'(CAPTURE_DEPTH));
	assign waddr   = ADDR_W'(channel) * ADDR_W'(CAPTURE_DEPTH) + ADDR_W'(cnt_q[channel]);
	assign ram_re  = (state_q == S_RD);
	assign raddr   = ADDR_W'(k_q) * ADDR_W'(CAPTURE_DEPTH) + ADDR_W'(i_q);
	assign rd_t    = rdata[TS_W-1:0];
	assign rd_l    = rdata[TS_W];
	assign gap_d   = abs_gap(rd_t, prev_t_q);
	assign rise_gap = last_rise_q[k_q] - first_rise_q[k_q];

	hefm_ram #(
		.WIDTH(TS_W + 1),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata({level, timestamp}),
		.re   (ram_re),
		.raddr(raddr),
		.rdata(rdata)
	);

	hefm_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (dreq),
		.rsp   (drsp)
	);

	// divider operands per sequencer step
	always_comb begin
		dreq.start = 1'b0;
		dreq.num   = '0;
		dreq.den   = '0;
		unique case (state_q)
			S_DUTY: begin
				dreq.num = NUM_W'(high_q) * K_PERMILLE;
				dreq.den = DEN_W'(total_q);
			end
			S_WFREQ: begin
				dreq.num = K_HALF_TICK * NUM_W'(p_q);
				dreq.den = DEN_W'(total_q);
			end
			S_RISE1: begin
				dreq.num = NUM_W'(rise_cnt_q[k_q] - TS_W'(1)) * K_RISE_MUL;
				dreq.den = DEN_W'(gap_q);
			end
			S_RISE2: begin
				dreq.num = NUM_W'(rrem_q) * K_GIGA;
				dreq.den = DEN_W'(gap_q);
			end
			S_PH1: begin
				dreq.num = K_TICK;
				dreq.den = DEN_W'(wfreq0_q);
			end
			S_PH2: begin
				dreq.num = NUM_W'(raw_q) * K_MDEG;
				dreq.den = per_q;
			end
			default: ;
		endcase
		dreq.start = (state_q == S_DUTY || state_q == S_WFREQ || state_q == S_RISE1 ||
			state_q == S_RISE2 || state_q == S_PH1 || state_q == S_PH2) && !wait_q;
	end

	// capture store control and rise trackers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				cnt_q[c]        <= '0;
				rise_cnt_q[c]   <= '0;
				first_rise_q[c] <= '0;
				last_rise_q[c]  <= '0;
			end
		end else if (in_acc && req_type == REQ_CLEAR) begin
			for (int c = 0; c < CHANNELS; c++) begin
				cnt_q[c]        <= '0;
				rise_cnt_q[c]   <= '0;
				first_rise_q[c] <= '0;
				last_rise_q[c]  <= '0;
			end
		end else if (in_acc && edge_ok) begin
			if (ram_we) begin
				cnt_q[channel] <= cnt_q[channel] + CNT_W'(1);
			end
			if (level) begin
				if (rise_cnt_q[channel] == '0) begin
					first_rise_q[channel] <= timestamp;
				end
				if (rise_cnt_q[channel] != SAT_VAL) begin
					rise_cnt_q[channel] <= rise_cnt_q[channel] + TS_W'(1);
				end
				last_rise_q[channel] <= timestamp;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wait_q  <= 1'b0;
			k_q     <= '0;
		end else begin
			if (dreq.start) begin
				wait_q <= 1'b1;
			end else if (drsp.done) begin
				wait_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && req_type == REQ_COMPUTE) begin
						k_q     <= '0;
						state_q <= S_WINIT;
					end
				end
				S_WINIT: state_q <= (cnt_q[k_q] == '0) ? S_EVAL : S_RD;
				S_RD:    state_q <= S_ACC;
				S_ACC:   state_q <= (i_q + CNT_W'(1) == n_q) ? S_EVAL : S_RD;
				S_EVAL: begin
					state_q <= (n_q > CNT_W'(3) && total_q != '0) ? S_DUTY : S_RSEL;
				end
				S_DUTY:  if (drsp.done) state_q <= S_WFREQ;
				S_WFREQ: if (drsp.done) state_q <= S_RSEL;
				S_RSEL: begin
					state_q <= (rise_cnt_q[k_q] > TS_W'(3) && rise_gap != '0) ?
						S_RISE1 : S_PSEL;
				end
				S_RISE1: begin
					if (drsp.done) begin
						state_q <= (drsp.quo > NUM_W'(4)) ? S_PSEL : S_RISE2;
					end
				end
				S_RISE2: if (drsp.done) state_q <= S_PSEL;
				S_PSEL: begin
					if (k_q != '0 && valid0_q && valid_q) begin
						state_q <= (wfreq0_q != '0) ? S_PH1 : S_OUT;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_PH1: if (drsp.done) state_q <= S_PH2;
				S_PH2: if (drsp.done) state_q <= S_OUT;
				S_OUT: begin
					if (out_acc) begin
						if (k_q == CH_W'(CHANNELS - 1)) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + CH_W'(1);
							state_q <= S_WINIT;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_WINIT: begin
				n_q     <= cnt_q[k_q];
				p_q     <= (cnt_q[k_q] > CNT_W'(3)) ?
					((cnt_q[k_q] - CNT_W'(1)) & ~CNT_W'(1)) : '0;
				i_q     <= '0;
				total_q <= '0;
				high_q  <= '0;
				found_q <= 1'b0;
				ref_q   <= '0;
			end
			S_ACC: begin
				if (rd_l && !found_q) begin
					found_q <= 1'b1;
					ref_q   <= rd_t;
				end
				if (i_q != '0 && i_q <= p_q) begin
					total_q <= total_q + SUM_W'(gap_d);
					if (prev_lvl_q) begin
						high_q <= high_q + SUM_W'(gap_d);
					end
				end
				prev_t_q   <= rd_t;
				prev_lvl_q <= rd_l;
				i_q        <= i_q + CNT_W'(1);
			end
			S_EVAL: begin
				valid_q <= n_q > CNT_W'(3);
				duty_q  <= '0;
				wfreq_q <= '0;
				phase_q <= '0;
			end
			S_DUTY:  if (drsp.done) duty_q <= drsp.quo[DUTY_W-1:0];
			S_WFREQ: if (drsp.done) wfreq_q <= sat32(drsp.quo);
			S_RSEL: begin
				gap_q <= rise_gap;
				if (rise_cnt_q[k_q] > TS_W'(3)) begin
					freq_q <= SAT_VAL;
				end else begin
					freq_q <= wfreq_q;
				end
				if (k_q == '0) begin
					valid0_q <= valid_q;
					wfreq0_q <= wfreq_q;
					aref_q   <= ref_q;
				end
			end
			S_RISE1: begin
				if (drsp.done) begin
					rq_q   <= drsp.quo[2:0];
					rrem_q <= drsp.rem[TS_W-1:0];
				end
			end
			S_RISE2: begin
				if (drsp.done) begin
					freq_q <= sat32(NUM_W'(rq_q) * K_GIGA + drsp.quo);
				end
			end
			S_PSEL: begin
				raw_q <= abs_gap(aref_q, ref_q);
				if (k_q != '0 && valid0_q && valid_q) begin
					phase_q <= abs_gap(aref_q, ref_q);
				end
			end
			S_PH1: if (drsp.done) per_q <= drsp.quo[DEN_W-1:0];
			S_PH2: if (drsp.done) phase_q <= sat32(drsp.quo);
			default: ;
		endcase
	end

	assign in_stall        = (state_q != S_IDLE);
	assign out_valid       = (state_q == S_OUT);
	assign result_channel  = k_q;
	assign window_valid    = valid_q;
	assign duty_permille   = duty_q;
	assign freq_millihertz = freq_q;
	assign phase_millideg  = phase_q;
	assign last_result     = (k_q == CH_W'(CHANNELS - 1));

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> (state_q == S_DUTY || state_q == S_WFREQ || state_q == S_RISE1 ||
			state_q == S_RISE2 || state_q == S_PH1 || state_q == S_PH2))
		else $error("divider finished outside a divide step");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (duty_q <= DUTY_W'(1000)))
		else $error("duty above 1000 permille");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_result) |=> (state_q == S_IDLE))
		else $error("compute did not end after last result");

	a_phase_a: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && k_q == '0) |-> (phase_q == '0))
		else $error("channel A phase not zero");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q[0] <= CNT_W'(CAPTURE_DEPTH)) && (cnt_q[CHANNELS-1] <= CNT_W'(CAPTURE_DEPTH)))
		else $error("edge count past capture depth");

endmodule

`default_nettype wire
